// ----- rtl/rcov_pkg.sv -----
// ----------------------------------------------------------------------------
// rcov_pkg
// shared constants, types and helpers for the ramdac cursor overlay core
// ----------------------------------------------------------------------------
package rcov_pkg;

  localparam int CURSOR_SIZE = 32;
  localparam int COORD_W     = $clog2(CURSOR_SIZE);
  localparam int PLANE_DEPTH = CURSOR_SIZE * CURSOR_SIZE / 8;
  localparam int PLANE_AW    = $clog2(PLANE_DEPTH);
  localparam int RAM_DEPTH   = 2 * PLANE_DEPTH;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);
  localparam int DIFF_W      = 14;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_PIXEL = 2'd2;

  localparam logic [2:0] SEL_INDEX     = 3'd0;
  localparam logic [2:0] SEL_INDEXED   = 3'd2;
  localparam logic [2:0] SEL_RAM_INDEX = 3'd4;
  localparam logic [2:0] SEL_RAM_DATA  = 3'd5;
  localparam logic [2:0] SEL_CMD_A     = 3'd6;

  localparam logic [7:0] IDX_CMD_B       = 8'd2;
  localparam logic [7:0] IDX_CURSOR_CTRL = 8'd3;
  localparam logic [7:0] IDX_POS_X_LO    = 8'd4;
  localparam logic [7:0] IDX_POS_X_HI    = 8'd5;
  localparam logic [7:0] IDX_POS_Y_LO    = 8'd6;
  localparam logic [7:0] IDX_POS_Y_HI    = 8'd7;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_3COLOR = 2'd1;
  localparam logic [1:0] MODE_PM     = 2'd2;
  localparam logic [1:0] MODE_XWIN   = 2'd3;

  localparam logic [1:0] CODE_CLEAR = 2'd0;
  localparam logic [1:0] CODE_P0    = 2'd1;
  localparam logic [1:0] CODE_P1    = 2'd2;
  localparam logic [1:0] CODE_BOTH  = 2'd3;

  localparam logic [7:0]  READ_NONE   = 8'hff;
  localparam logic [23:0] INVERT_MASK = 24'hffffff;

  localparam logic [2:0] DEPTH_8  = 3'd0;
  localparam logic [2:0] DEPTH_15 = 3'd1;
  localparam logic [2:0] DEPTH_16 = 3'd2;
  localparam logic [2:0] DEPTH_24 = 3'd3;
  localparam logic [2:0] DEPTH_32 = 3'd4;

  typedef struct packed {
    logic [7:0]          read_data;
    logic [2:0]          depth;
    logic                swap;
    logic                is_pix;
    logic                hit;
    logic [1:0]          mode;
    logic [2:0]          bit_sel;
    logic [23:0]         color1;
    logic [23:0]         color2;
    logic [23:0]         color3;
    logic [23:0]         pixel;
  } item_t;

  function automatic logic [2:0] depth_of(input logic [7:0] cmd);
    logic [2:0] d;
    case (cmd[7:4])
      4'hf:        d = DEPTH_24;
      4'h9, 4'hb:  d = DEPTH_32;
      4'hc, 4'he:  d = DEPTH_16;
      4'h8, 4'ha:  d = DEPTH_15;
      default:     d = DEPTH_8;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/rcov_ram.sv -----
// ----------------------------------------------------------------------------
// rcov_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rcov_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rcov_regs.sv -----
// ----------------------------------------------------------------------------
// rcov_regs
// bus register file, cursor ram planes and cursor hit lookup for one request
// ----------------------------------------------------------------------------
module rcov_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 acc,
  input  logic [1:0]           req_type,
  input  logic [2:0]           reg_select,
  input  logic [7:0]           write_data,
  input  logic [11:0]          pixel_x,
  input  logic [11:0]          pixel_y,
  input  logic [23:0]          underlying_pixel,
  output rcov_pkg::item_t      item,
  output logic [7:0]           plane0,
  output logic [7:0]           plane1
);

  logic [7:0]  command_a;
  logic [7:0]  command_b;
  logic [7:0]  cursor_control;
  logic [11:0] cursor_pos_x;
  logic [11:0] cursor_pos_y;
  logic [7:0]  register_index;
  logic [1:0]  color_byte_step;
  logic [7:0]  staged_color_bytes [2];
  logic [23:0] cursor_colors [1:3];
  logic [rcov_pkg::RAM_DEPTH-1:0] ram_vld;
  logic        vld0;
  logic        vld1;

  logic        wr;
  logic        ram_wr;
  logic        we0;
  logic        we1;
  logic [7:0]  command_a_next;
  logic [7:0]  rd;
  logic [rcov_pkg::DIFF_W-1:0] dx;
  logic [rcov_pkg::DIFF_W-1:0] dy;
  logic        hit;
  logic [rcov_pkg::PLANE_AW-1:0] rd_addr;
  logic [7:0]  q0;
  logic [7:0]  q1;

  assign wr     = acc && (req_type == rcov_pkg::REQ_WRITE);
  assign ram_wr = wr && (reg_select == rcov_pkg::SEL_RAM_DATA) && cursor_control[3];
  assign we0    = ram_wr && !register_index[rcov_pkg::PLANE_AW];
  assign we1    = ram_wr && register_index[rcov_pkg::PLANE_AW];

  always_comb begin
    command_a_next = command_a;
    if (wr && (reg_select == rcov_pkg::SEL_CMD_A)) begin
      command_a_next = write_data;
    end
  end

  // bus read mux
  always_comb begin
    rd = rcov_pkg::READ_NONE;
    if (reg_select == rcov_pkg::SEL_CMD_A) begin
      rd = command_a;
    end else if ((reg_select == rcov_pkg::SEL_INDEXED) && command_a[0]) begin
      case (register_index)
        rcov_pkg::IDX_CMD_B:       rd = command_b;
        rcov_pkg::IDX_CURSOR_CTRL: rd = cursor_control;
        rcov_pkg::IDX_POS_X_LO:    rd = cursor_pos_x[7:0];
        rcov_pkg::IDX_POS_X_HI:    rd = {4'd0, cursor_pos_x[11:8]};
        rcov_pkg::IDX_POS_Y_LO:    rd = cursor_pos_y[7:0];
        rcov_pkg::IDX_POS_Y_HI:    rd = {4'd0, cursor_pos_y[11:8]};
        default:                   rd = rcov_pkg::READ_NONE;
      endcase
    end
  end

  // cursor window: offset of the pixel from position minus cursor size
  assign dx = {2'd0, pixel_x} + rcov_pkg::DIFF_W'(rcov_pkg::CURSOR_SIZE) - {2'd0, cursor_pos_x};
  assign dy = {2'd0, pixel_y} + rcov_pkg::DIFF_W'(rcov_pkg::CURSOR_SIZE) - {2'd0, cursor_pos_y};
  assign hit = (dx[rcov_pkg::DIFF_W-1:rcov_pkg::COORD_W] == '0)
            && (dy[rcov_pkg::DIFF_W-1:rcov_pkg::COORD_W] == '0);
  assign rd_addr = {dy[rcov_pkg::COORD_W-1:0], dx[rcov_pkg::COORD_W-1:3]};

  always_comb begin
    item           = '0;
    item.read_data = (acc && (req_type == rcov_pkg::REQ_READ)) ? rd : rcov_pkg::READ_NONE;
    item.depth     = rcov_pkg::depth_of(command_a_next);
    item.swap      = (rcov_pkg::depth_of(command_a_next) >= rcov_pkg::DEPTH_24)
                  && !command_a_next[1];
    item.is_pix    = (req_type == rcov_pkg::REQ_PIXEL);
    item.hit       = hit;
    item.mode      = cursor_control[1:0];
    item.bit_sel   = dx[2:0];
    item.color1    = cursor_colors[1];
    item.color2    = cursor_colors[2];
    item.color3    = cursor_colors[3];
    item.pixel     = underlying_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_a             <= '0;
      command_b             <= '0;
      cursor_control        <= '0;
      cursor_pos_x          <= '0;
      cursor_pos_y          <= '0;
      register_index        <= '0;
      color_byte_step       <= '0;
      staged_color_bytes[0] <= '0;
      staged_color_bytes[1] <= '0;
      cursor_colors[1]      <= '0;
      cursor_colors[2]      <= '0;
      cursor_colors[3]      <= '0;
    end else if (wr) begin
      case (reg_select)
        rcov_pkg::SEL_INDEX: begin
          register_index <= write_data;
        end
        rcov_pkg::SEL_INDEXED: begin
          if (command_a[0]) begin
            case (register_index)
              rcov_pkg::IDX_CMD_B:       command_b <= write_data;
              rcov_pkg::IDX_CURSOR_CTRL: cursor_control <= write_data;
              rcov_pkg::IDX_POS_X_LO:    cursor_pos_x[7:0] <= write_data;
              rcov_pkg::IDX_POS_X_HI:    cursor_pos_x[11:8] <= write_data[3:0];
              rcov_pkg::IDX_POS_Y_LO:    cursor_pos_y[7:0] <= write_data;
              rcov_pkg::IDX_POS_Y_HI:    cursor_pos_y[11:8] <= write_data[3:0];
              default: ;
            endcase
          end
        end
        rcov_pkg::SEL_RAM_INDEX: begin
          register_index  <= write_data;
          color_byte_step <= '0;
        end
        rcov_pkg::SEL_RAM_DATA: begin
          if (cursor_control[3]) begin
            register_index <= register_index + 8'd1;
          end else if (color_byte_step < 2'd2) begin
            staged_color_bytes[color_byte_step[0]] <= write_data;
            color_byte_step <= color_byte_step + 2'd1;
          end else begin
            // color 0 is never shown, so it is not stored
            if (register_index[1:0] != 2'd0) begin
              cursor_colors[register_index[1:0]] <=
                {staged_color_bytes[0], staged_color_bytes[1], write_data};
            end
            register_index  <= register_index + 8'd1;
            color_byte_step <= '0;
          end
        end
        rcov_pkg::SEL_CMD_A: begin
          command_a <= write_data;
        end
        default: ;
      endcase
    end
  end

  // per-byte written flags stand in for the ram's zero reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_vld <= '0;
      vld0    <= 1'b0;
      vld1    <= 1'b0;
    end else begin
      if (ram_wr) begin
        ram_vld[register_index] <= 1'b1;
      end
      if (acc) begin
        vld0 <= ram_vld[{1'b0, rd_addr}];
        vld1 <= ram_vld[{1'b1, rd_addr}];
      end
    end
  end

  rcov_ram #(
    .WIDTH (8),
    .DEPTH (rcov_pkg::PLANE_DEPTH)
  ) u_plane0 (
    .clk   (clk),
    .we    (we0),
    .waddr (register_index[rcov_pkg::PLANE_AW-1:0]),
    .wdata (write_data),
    .re    (acc),
    .raddr (rd_addr),
    .rdata (q0)
  );

  rcov_ram #(
    .WIDTH (8),
    .DEPTH (rcov_pkg::PLANE_DEPTH)
  ) u_plane1 (
    .clk   (clk),
    .we    (we1),
    .waddr (register_index[rcov_pkg::PLANE_AW-1:0]),
    .wdata (write_data),
    .re    (acc),
    .raddr (rd_addr),
    .rdata (q1)
  );

  assign plane0 = q0 & {8{vld0}};
  assign plane1 = q1 & {8{vld1}};

endmodule

// ----- rtl/rcov_blend.sv -----
// ----------------------------------------------------------------------------
// rcov_blend
// cursor compositing of one pixel from the two plane bits and the mode
// ----------------------------------------------------------------------------
module rcov_blend (
  input  rcov_pkg::item_t item,
  input  logic [7:0]      plane0,
  input  logic [7:0]      plane1,
  output logic [23:0]     pixel_out
);

  logic [2:0]  bidx;
  logic [1:0]  code;
  logic [23:0] cur;

  // leftmost pixel sits in bit 7
  assign bidx = ~item.bit_sel;
  assign code = {plane1[bidx], plane0[bidx]};

  always_comb begin
    cur = item.pixel;
    case (item.mode)
      rcov_pkg::MODE_3COLOR: begin
        case (code)
          rcov_pkg::CODE_P0:   cur = item.color1;
          rcov_pkg::CODE_P1:   cur = item.color2;
          rcov_pkg::CODE_BOTH: cur = item.color3;
          default:             cur = item.pixel;
        endcase
      end
      rcov_pkg::MODE_PM: begin
        case (code)
          rcov_pkg::CODE_CLEAR: cur = item.color1;
          rcov_pkg::CODE_P0:    cur = item.color2;
          rcov_pkg::CODE_BOTH:  cur = item.pixel ^ rcov_pkg::INVERT_MASK;
          default:              cur = item.pixel;
        endcase
      end
      rcov_pkg::MODE_XWIN: begin
        case (code)
          rcov_pkg::CODE_P1:   cur = item.color1;
          rcov_pkg::CODE_BOTH: cur = item.color2;
          default:             cur = item.pixel;
        endcase
      end
      default: cur = item.pixel;
    endcase
  end

  always_comb begin
    if (!item.is_pix) begin
      pixel_out = '0;
    end else if (!item.hit) begin
      pixel_out = item.pixel;
    end else begin
      pixel_out = cur;
    end
  end

endmodule

// ----- rtl/ramdac_cursor_overlay_regs_core.sv -----
// ----------------------------------------------------------------------------
// ramdac_cursor_overlay_regs_core
// pipeline: 2 register stages, lookup then output; a request passes both in that order
// throughput: one request per cycle if not stalled; each plane ram has its own r/w port
// stalls: input waits only while the lookup stage holds a request the output can't take
// reset: synchronous, clears control state, valid flags and the cursor ram written flags
// ----------------------------------------------------------------------------
module ramdac_cursor_overlay_regs_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // write_data, pixel_x, pixel_y, underlying_pixel
  input  logic [4:0]  s_tuser,   // req_type, reg_select
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // read_data, pixel_out
  output logic [3:0]  m_tuser    // depth_code, swap_red_blue
);

  logic            acc;
  logic            adv;
  logic            s1_valid;
  rcov_pkg::item_t item;
  rcov_pkg::item_t s1;
  logic [7:0]      plane0;
  logic [7:0]      plane1;
  logic [23:0]     pixel_out;

  assign acc      = s_tvalid && s_tready;
  assign adv      = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || adv;

  rcov_regs u_regs (
    .clk              (clk),
    .rst              (rst),
    .acc              (acc),
    .req_type         (s_tuser[1:0]),
    .reg_select       (s_tuser[4:2]),
    .write_data       (s_tdata[7:0]),
    .pixel_x          (s_tdata[19:8]),
    .pixel_y          (s_tdata[31:20]),
    .underlying_pixel (s_tdata[55:32]),
    .item             (item),
    .plane0           (plane0),
    .plane1           (plane1)
  );

  rcov_blend u_blend (
    .item      (s1),
    .plane0    (plane0),
    .plane1    (plane1),
    .pixel_out (pixel_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1 <= item;
    end
    if (adv) begin
      m_tdata <= {pixel_out, s1.read_data};
      m_tuser <= {s1.swap, s1.depth};
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    acc |=> s1_valid)
    else $error("accepted request did not reach the lookup stage");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("request accepted while pipeline is full and stalled");

  a_advance_shows_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> m_tvalid)
    else $error("result lost on its way to the output register");

  a_nonpixel_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1.is_pix) |-> (pixel_out == 24'd0))
    else $error("non-pixel request produced a pixel value");

  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[2:0] <= rcov_pkg::DEPTH_32))
    else $error("depth code out of range");
`endif

endmodule
